// ----- hdl/ipv4fhb_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4fhb_pkg
// Types and constants shared by the IPv4 fragment header builder.
// ----------------------------------------------------------------------------
package ipv4fhb_pkg;

  localparam int unsigned HDR_BYTES   = 20;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS);
  localparam int unsigned SUM_W       = 20;
  localparam logic [15:0] VER_IHL_TOS = 16'h4500;
  localparam logic [7:0]  TTL_RESET   = 8'd64;

  localparam logic CFG_SOURCE_ADDRESS = 1'b0;
  localparam logic CFG_TIME_TO_LIVE   = 1'b1;

  typedef struct packed {
    logic [15:0] payload_length;
    logic [31:0] destination_address;
    logic [7:0]  upper_protocol;
  } in_word_t;

  typedef struct packed {
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [10:0] total_length;
    logic [15:0] datagram_ident;
    logic [15:0] header_sum;
    logic        last_fragment;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_CALC,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic capture;
    logic base;
    logic calc;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic frag_last;
    logic load_ok;
  } status_t;

endpackage

// ----- hdl/ipv4fhb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipv4fhb_ctrl
// Sequencer: takes a datagram, sets up the base sum, then steps through the
// fragments, one calculate and one output load per fragment.
// ----------------------------------------------------------------------------
module ipv4fhb_ctrl
  import ipv4fhb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BASE;
      end
      ST_BASE: state_d = ST_CALC;
      ST_CALC: state_d = ST_LOAD;
      ST_LOAD: begin
        if (status_i.load_ok) state_d = status_i.frag_last ? ST_IDLE : ST_CALC;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.base    = (state_q == ST_BASE);
    cmd_o.calc    = (state_q == ST_CALC);
    cmd_o.load    = (state_q == ST_LOAD) && status_i.load_ok;
  end

endmodule

// ----- hdl/ipv4fhb_dp.sv -----
// ----------------------------------------------------------------------------
// ipv4fhb_dp
// Datapath: configuration registers, identifier counter, fragment walk,
// checksum accumulate and fold, output register.
// ----------------------------------------------------------------------------
module ipv4fhb_dp
  import ipv4fhb_pkg::*;
#(
  parameter int unsigned MTU_BYTES = 1500
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  in_word_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam int unsigned FRAG_UNITS = (MTU_BYTES - HDR_BYTES) / 8;
  localparam logic [10:0] FRAG_BYTES = 11'(FRAG_UNITS * 8);
  localparam logic [12:0] UNIT_STEP  = 13'(FRAG_UNITS);

  logic [31:0] src_q;
  logic [7:0]  ttl_q;
  logic [15:0] ident_ctr_q;

  logic [15:0] remain_q;
  logic [15:0] ident_q;
  logic [15:0] src_part;
  logic [SUM_W-1:0] base_q;
  logic [12:0] offset_q;
  logic [CNT_W-1:0] count_q;

  logic [12:0] f_offset_q;
  logic        f_mf_q;
  logic [10:0] f_total_q;
  logic        f_last_q;
  logic [SUM_W-1:0] f_raw_q;

  logic        out_valid_q;
  out_word_t   out_q;

  logic        fits;
  logic        last_c;
  logic [10:0] piece;
  logic [10:0] total_c;
  logic [16:0] fold1;
  logic [15:0] fold2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      ttl_q       <= TTL_RESET;
      ident_ctr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SOURCE_ADDRESS: src_q <= cfg_data_i;
          CFG_TIME_TO_LIVE:   ttl_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) ident_ctr_q <= ident_ctr_q + 16'd1;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign src_part = src_q[31:16];
  assign fits     = (remain_q <= {5'd0, FRAG_BYTES});
  assign last_c   = fits || (count_q == CNT_W'(MAX_RESULTS - 1));
  assign piece    = fits ? remain_q[10:0] : FRAG_BYTES;
  assign total_c  = piece + 11'(HDR_BYTES);
  assign fold1    = {1'b0, f_raw_q[15:0]} + {13'd0, f_raw_q[SUM_W-1:16]};
  assign fold2    = fold1[15:0] + {15'd0, fold1[16]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      remain_q <= in_data_i.payload_length;
      ident_q  <= ident_ctr_q;
      base_q   <= SUM_W'(VER_IHL_TOS)
                + SUM_W'({ttl_q, in_data_i.upper_protocol})
                + SUM_W'(in_data_i.destination_address[31:16])
                + SUM_W'(in_data_i.destination_address[15:0]);
      offset_q <= '0;
      count_q  <= '0;
    end
    if (cmd_i.base) begin
      base_q <= base_q + SUM_W'(ident_q) + SUM_W'(src_part) + SUM_W'(src_q[15:0]);
    end
    if (cmd_i.calc) begin
      f_offset_q <= offset_q;
      f_mf_q     <= ~last_c;
      f_total_q  <= total_c;
      f_last_q   <= last_c;
      f_raw_q    <= base_q + SUM_W'(total_c) + SUM_W'({~last_c, offset_q});
      remain_q   <= remain_q - {5'd0, piece};
      offset_q   <= offset_q + UNIT_STEP;
      count_q    <= count_q + CNT_W'(1);
    end
    if (cmd_i.load) begin
      out_q.offset_units   <= f_offset_q;
      out_q.more_fragments <= f_mf_q;
      out_q.total_length   <= f_total_q;
      out_q.datagram_ident <= ident_q;
      out_q.header_sum     <= ~fold2;
      out_q.last_fragment  <= f_last_q;
    end
  end

  assign status_o.frag_last = f_last_q;
  assign status_o.load_ok   = ~out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

// ----- hdl/ipv4_fragment_header_builder.sv -----
// ----------------------------------------------------------------------------
// ipv4_fragment_header_builder
// Splits one datagram into fragments and emits one IPv4 header word per
// fragment with offset, flags, length, identifier and header checksum.
// ----------------------------------------------------------------------------
// the first header word is registered at the output after the base, calculate
// and load steps of the sequencer; then one calculate and one load step per
//   fragment (at most 64), the load held while the output word is not taken
// a new datagram is taken while the final header word still waits at the output
// reset: identifier counter 0, source address 0, ttl 64, output empty
module ipv4_fragment_header_builder
  import ipv4fhb_pkg::*;
#(
  parameter int unsigned MTU_BYTES = 1500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  cmd_t    cmd;
  status_t status;

  ipv4fhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ipv4fhb_dp #(
    .MTU_BYTES (MTU_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
